// ===== rtl/core/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the status frame deframer: header bytes,
// phase codes, item kinds and the result record.
// ----------------------------------------------------------------------------
package sfs_pkg;

	localparam int JOINT_COUNT_DEF = 7;
	localparam int HDR_LEN         = 15;
	localparam int HIST_LEN        = HDR_LEN - 1;
	localparam int SERIAL_LEN      = 4;

	localparam logic [7:0] SYNC_HDR [HDR_LEN] = '{
		8'h52, 8'h52, 8'h31, 8'h2D, 8'h72, 8'h65, 8'h76, 8'h2E,
		8'h32, 8'h2D, 8'h72, 8'h6F, 8'h62, 8'h6F, 8'h74
	};

	typedef enum logic [1:0] {
		PH_HUNT   = 2'd0,
		PH_SERIAL = 2'd1,
		PH_JOINT  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SERIAL   = 2'd0,
		KIND_ENCODER  = 2'd1,
		KIND_EXECUTED = 2'd2
	} kind_t;

	typedef struct packed {
		logic               valid;
		kind_t              item_kind;
		logic [2:0]         joint_index;
		logic signed [31:0] joint_value;
		logic [31:0]        serial_code;
		logic               frame_last;
	} result_t;

endpackage

// ===== rtl/core/sfs_byte_if.sv =====
// ----------------------------------------------------------------------------
// sfs_byte_if
// Request channel carrying one received serial byte.
// ----------------------------------------------------------------------------
interface sfs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/sfs_item_if.sv =====
// ----------------------------------------------------------------------------
// sfs_item_if
// Request channel carrying one decoded frame item.
// ----------------------------------------------------------------------------
interface sfs_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         item_kind;
	logic [2:0]         joint_index;
	logic signed [31:0] joint_value;
	logic [31:0]        serial_code;
	logic               frame_last;

	modport source (output valid, output item_kind, output joint_index,
		output joint_value, output serial_code, output frame_last, input ready);
	modport sink   (input valid, input item_kind, input joint_index,
		input joint_value, input serial_code, input frame_last, output ready);
endinterface

// ===== rtl/core/sfs_parser.sv =====
// ----------------------------------------------------------------------------
// sfs_parser
// Frame state and byte decode: header hunt over the byte history, serial
// capture and little-endian joint word assembly. One byte per step.
// ----------------------------------------------------------------------------
module sfs_parser
	import sfs_pkg::*;
#(
	parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output result_t    res
);

	localparam logic [3:0] JC_W   = 4'(JOINT_COUNT);
	localparam logic [3:0] LAST_W = 4'(2 * JOINT_COUNT - 1);
	localparam logic [5:0] SER_LAST = 6'(SERIAL_LEN - 1);

	logic [7:0]  recent_q [HIST_LEN];
	phase_t      phase_q;
	logic [5:0]  pos_q;
	logic [23:0] partial_q;

	logic [7:0]  recent_d [HIST_LEN];
	phase_t      phase_d;
	logic [5:0]  pos_d;
	logic [23:0] partial_d;
	logic        hit;
	logic [1:0]  k;
	logic [3:0]  w;
	logic [3:0]  w_exec;
	logic        last;

	always_comb begin
		hit = (rx_byte == SYNC_HDR[HDR_LEN-1]);
		for (int i = 0; i < HIST_LEN; i++) begin
			if (recent_q[i] != SYNC_HDR[i]) begin
				hit = 1'b0;
			end
		end
	end

	assign k      = pos_q[1:0];
	assign w      = pos_q[5:2];
	assign w_exec = w - JC_W;
	assign last   = (w >= LAST_W);

	always_comb begin
		recent_d  = recent_q;
		phase_d   = phase_q;
		pos_d     = pos_q;
		partial_d = partial_q;
		res       = '0;
		unique case (phase_q)
			PH_SERIAL: begin
				if (pos_q < SER_LAST) begin
					partial_d = {partial_q[15:0], rx_byte};
					pos_d     = pos_q + 6'd1;
				end else begin
					res.valid       = 1'b1;
					res.item_kind   = KIND_SERIAL;
					res.serial_code = {partial_q, rx_byte};
					phase_d         = PH_JOINT;
					pos_d           = '0;
					partial_d       = '0;
				end
			end
			PH_JOINT: begin
				if (k != 2'd3) begin
					unique case (k)
						2'd0:    partial_d = {16'd0, rx_byte};
						2'd1:    partial_d = {partial_q[23:16], rx_byte, partial_q[7:0]};
						default: partial_d = {rx_byte, partial_q[15:0]};
					endcase
					pos_d = pos_q + 6'd1;
				end else begin
					res.valid       = 1'b1;
					res.joint_value = {rx_byte, partial_q};
					res.frame_last  = last;
					if (w < JC_W) begin
						res.item_kind   = KIND_ENCODER;
						res.joint_index = w[2:0];
					end else begin
						res.item_kind   = KIND_EXECUTED;
						res.joint_index = w_exec[2:0];
					end
					partial_d = '0;
					if (last) begin
						phase_d = PH_HUNT;
						pos_d   = '0;
					end else begin
						pos_d = pos_q + 6'd1;
					end
				end
			end
			default: begin
				if (hit) begin
					for (int i = 0; i < HIST_LEN; i++) begin
						recent_d[i] = '0;
					end
					phase_d   = PH_SERIAL;
					pos_d     = '0;
					partial_d = '0;
				end else begin
					for (int i = 0; i < HIST_LEN - 1; i++) begin
						recent_d[i] = recent_q[i+1];
					end
					recent_d[HIST_LEN-1] = rx_byte;
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_LEN; i++) begin
				recent_q[i] <= '0;
			end
			phase_q   <= PH_HUNT;
			pos_q     <= '0;
			partial_q <= '0;
		end else if (step) begin
			recent_q  <= recent_d;
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			partial_q <= partial_d;
		end
	end

endmodule

// ===== rtl/core/status_frame_sync_deframer.sv =====
// ----------------------------------------------------------------------------
// status_frame_sync_deframer
// Finds the 15-byte status header in a received byte stream and reports the
// serial number and the encoder and executed joint positions of each frame.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle unless the output side stalls. A byte is held in an input
// register, decoded against the frame state when it leaves that register and its result
// (if any) lands in an output register, where the item is presented until it is
// taken. The
// output register frees the input side: a new byte is taken while a result
// waits, and input stalls only when both the input register and the output
// register are full. Bytes outside a frame
// produce no item; the serial number comes as one item after its fourth
// character, each joint word after its fourth byte, the final word marked
// with frame_last.
module status_frame_sync_deframer
	import sfs_pkg::*;
#(
	parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sfs_byte_if.sink   rx,
	sfs_item_if.source items
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	result_t    out_q;
	result_t    res;
	logic       advance;
	logic       take;

	assign advance  = valid_s1 && (!out_valid_q || items.ready);
	assign rx.ready = !valid_s1 || advance;
	assign take     = rx.valid && rx.ready;

	sfs_parser #(
		.JOINT_COUNT(JOINT_COUNT)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (items.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_q <= res;
		end
	end

	assign items.valid       = out_valid_q;
	assign items.item_kind   = out_q.item_kind;
	assign items.joint_index = out_q.joint_index;
	assign items.joint_value = out_q.joint_value;
	assign items.serial_code = out_q.serial_code;
	assign items.frame_last  = out_q.frame_last;

endmodule

// ===== verif/tb_status_frame_sync_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_status_frame_sync_deframer
// Self-checking bench for the status frame deframer. Received bytes are fed
// from a queue: first a directed sequence, then random well-formed frames
// mixed with noise and broken headers. A byte-level deframer in the bench
// predicts every decoded item, and each item taken from the block is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_status_frame_sync_deframer import sfs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int JC          = JOINT_COUNT_DEF;
	localparam int BYTE_TARGET = 700;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #6 clk = ~clk;

	sfs_byte_if rx_if ();
	sfs_item_if item_if ();

	logic       src_valid = 1'b0;
	logic [7:0] src_byte  = 8'h00;
	logic       snk_ready = 1'b0;

	assign rx_if.valid   = src_valid;
	assign rx_if.rx_byte = src_byte;
	assign item_if.ready = snk_ready;

	status_frame_sync_deframer #(
		.JOINT_COUNT(JC)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_if),
		.items (item_if)
	);

	logic [7:0] byte_queue [$];
	result_t    expected_items [$];
	int         bytes_queued   = 0;
	int         bytes_accepted = 0;
	int         headers_found  = 0;
	int         items_checked  = 0;
	int         mismatches     = 0;

	// bench copy of the deframer state
	logic [7:0] hist [HIST_LEN] = '{default: 8'h00};
	phase_t     phase           = PH_HUNT;
	logic [5:0] pos             = '0;
	logic [23:0] partial        = '0;

	function automatic bit take_gap();
		if (bytes_accepted >= 350 && bytes_accepted < 500)
			return 1'b0;
		return $urandom_range(0, 99) < 12;
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		result_t     r;
		logic [1:0]  k;
		logic [3:0]  w;
		bit          hit;
		int          i;
		r = '0;
		r.valid = 1'b1;
		case (phase)
			PH_SERIAL: begin
				if (pos < SERIAL_LEN - 1) begin
					partial = {partial[15:0], b};
					pos = pos + 6'd1;
				end else begin
					r.item_kind   = KIND_SERIAL;
					r.serial_code = {partial, b};
					expected_items = {expected_items, r};
					phase   = PH_JOINT;
					pos     = '0;
					partial = '0;
				end
			end
			PH_JOINT: begin
				k = pos[1:0];
				w = pos[5:2];
				if (k != 2'd3) begin
					if (k == 2'd0)
						partial = {16'h0000, b};
					else
						partial = partial | (24'(b) << (8 * k));
					pos = pos + 6'd1;
				end else begin
					r.item_kind   = (w < JC) ? KIND_ENCODER : KIND_EXECUTED;
					r.joint_index = (w < JC) ? w[2:0] : 3'(w - JC);
					r.joint_value = {b, partial};
					r.frame_last  = (w >= 2 * JC - 1);
					expected_items = {expected_items, r};
					partial = '0;
					if (r.frame_last) begin
						phase = PH_HUNT;
						pos   = '0;
					end else begin
						pos = pos + 6'd1;
					end
				end
			end
			default: begin
				hit = (b == SYNC_HDR[HDR_LEN-1]);
				for (i = 0; i < HIST_LEN; i++)
					if (hist[i] != SYNC_HDR[i])
						hit = 1'b0;
				if (hit) begin
					for (i = 0; i < HIST_LEN; i++)
						hist[i] = 8'h00;
					phase   = PH_SERIAL;
					pos     = '0;
					partial = '0;
					headers_found++;
				end else begin
					for (i = 0; i < HIST_LEN - 1; i++)
						hist[i] = hist[i+1];
					hist[HIST_LEN-1] = b;
					phase = PH_HUNT;
				end
			end
		endcase
	endtask

	// byte request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && rx_if.ready) begin
				deframe_byte(src_byte);
				bytes_accepted++;
			end
			if (!src_valid || rx_if.ready) begin
				if (byte_queue.size() != 0 && !take_gap()) begin
					src_valid <= 1'b1;
					src_byte  <= byte_queue.pop_front();
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// item request monitor
	always @(posedge clk) begin : item_monitor
		result_t want;
		if (arst_n) begin
			if (item_if.valid && snk_ready) begin
				items_checked++;
				if (expected_items.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: kind %0d idx %0d value %h serial %h last %b",
							item_if.item_kind, item_if.joint_index, item_if.joint_value,
							item_if.serial_code, item_if.frame_last);
				end else begin
					want = expected_items.pop_front();
					if (item_if.item_kind !== want.item_kind ||
						item_if.joint_index !== want.joint_index ||
						item_if.joint_value !== want.joint_value ||
						item_if.serial_code !== want.serial_code ||
						item_if.frame_last !== want.frame_last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("item %0d: expected kind %0d idx %0d value %h serial %h last %b",
								items_checked, want.item_kind, want.joint_index,
								want.joint_value, want.serial_code, want.frame_last);
							$display("item %0d: got kind %0d idx %0d value %h serial %h last %b",
								items_checked, item_if.item_kind, item_if.joint_index,
								item_if.joint_value, item_if.serial_code, item_if.frame_last);
						end
					end
				end
			end
			snk_ready <= !take_gap();
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		byte_queue = {byte_queue, b};
		bytes_queued++;
	endtask

	task automatic queue_header(input int n);
		int i;
		for (i = 0; i < n; i++)
			queue_byte(SYNC_HDR[i]);
	endtask

	task automatic queue_serial(input logic [31:0] s);
		queue_byte(s[31:24]);
		queue_byte(s[23:16]);
		queue_byte(s[15:8]);
		queue_byte(s[7:0]);
	endtask

	task automatic queue_word(input logic [31:0] w);
		queue_byte(w[7:0]);
		queue_byte(w[15:8]);
		queue_byte(w[23:16]);
		queue_byte(w[31:24]);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic wait_drained();
		while (bytes_accepted != bytes_queued || expected_items.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int i;
		int n;
		logic [31:0] s;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extreme bytes, then a header behind an extra leading R
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h52);
		queue_header(HDR_LEN);
		queue_serial(32'h00FF_7F80);
		queue_word(32'h8000_0000);
		queue_word(32'h7FFF_FFFF);
		queue_word(32'h0000_0000);
		queue_word(32'hFFFF_FFFF);
		// header bytes inside a frame must not be detected
		for (i = 0; i < 16; i++)
			queue_byte(i < HDR_LEN ? SYNC_HDR[i] : 8'h00);
		for (i = 0; i < 2 * JC - 8; i++)
			queue_word(pick_word());
		// near miss straight after the frame, then a full header
		queue_header(HDR_LEN - 1);
		queue_byte(8'h00);
		queue_header(HDR_LEN);
		queue_serial(32'h3030_3030);
		for (i = 0; i < 2 * JC; i++)
			queue_word(pick_word());

		// sender holds off until every item has come back
		wait_drained();

		while (bytes_queued < BYTE_TARGET) begin
			n = $urandom_range(0, 99);
			if (n < 65) begin
				repeat ($urandom_range(0, 3))
					queue_byte(8'($urandom_range(0, 255)));
				queue_header(HDR_LEN);
				if ($urandom_range(0, 1))
					for (i = 0; i < 4; i++)
						s = {s[23:0], 8'($urandom_range(8'h30, 8'h7A))};
				else
					s = $urandom;
				queue_serial(s);
				for (i = 0; i < 2 * JC; i++)
					queue_word(pick_word());
			end else if (n < 80) begin
				repeat ($urandom_range(1, 8))
					if ($urandom_range(0, 1))
						queue_byte(SYNC_HDR[$urandom_range(0, HDR_LEN - 1)]);
					else
						queue_byte(8'($urandom_range(0, 255)));
			end else begin
				queue_header($urandom_range(1, HDR_LEN - 1));
				queue_byte(8'($urandom_range(0, 255)));
			end
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (expected_items.size() != 0) begin
			mismatches += expected_items.size();
			$display("%0d expected items never arrived", expected_items.size());
		end
		$display("run covered %0d bytes, %0d headers found, %0d items checked",
			bytes_accepted, headers_found, items_checked);
		if (mismatches == 0) begin
			$display("status_frame_sync_deframer: match");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status_frame_sync_deframer: mismatch");
		end
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("timeout after %0d of %0d bytes", bytes_accepted, bytes_queued);
		$display("status_frame_sync_deframer: mismatch");
		$finish;
	end

endmodule
